### design/sdf_pkg.sv
package sdf_pkg;

    localparam int GAIN_BITS     = 16;
    localparam int COUNT_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (GAIN_BITS > COUNT_BITS) ? GAIN_BITS : COUNT_BITS;

    // |present - target| above this needs a transition (0.001 of full scale)
    localparam logic [GAIN_BITS-1:0] DIFF_TOL = GAIN_BITS'((2 ** GAIN_BITS) / 1000);

    localparam logic [GAIN_BITS-1:0]  TRIGGER_RST  = GAIN_BITS'(66);
    localparam logic [GAIN_BITS-1:0]  DUCKED_RST   = GAIN_BITS'(13107);
    localparam logic [GAIN_BITS-1:0]  FULL_RST     = GAIN_BITS'(65535);
    localparam logic [GAIN_BITS-1:0]  RESTORE_RST  = GAIN_BITS'(65535);
    localparam logic [GAIN_BITS-1:0]  STEP_RST     = GAIN_BITS'(3277);
    localparam logic [COUNT_BITS-1:0] TO_DUCK_RST  = COUNT_BITS'(3);
    localparam logic [COUNT_BITS-1:0] TO_REL_RST   = COUNT_BITS'(20);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TRIGGER_LEVEL    = 3'd0,
        REG_DUCKED_GAIN      = 3'd1,
        REG_FULL_GAIN        = 3'd2,
        REG_RESTORE_GAIN     = 3'd3,
        REG_FADE_STEP        = 3'd4,
        REG_TICKS_TO_DUCK    = 3'd5,
        REG_TICKS_TO_RELEASE = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0]  trigger_level;
        logic [GAIN_BITS-1:0]  ducked_gain;
        logic [GAIN_BITS-1:0]  full_gain;
        logic [GAIN_BITS-1:0]  restore_gain;
        logic [GAIN_BITS-1:0]  fade_step;
        logic [COUNT_BITS-1:0] ticks_to_duck;
        logic [COUNT_BITS-1:0] ticks_to_release;
    } cfg_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] peak_level;
        logic [GAIN_BITS-1:0] present_gain;
        logic                 channel_found;
        logic                 bypass_on;
    } item_t;

    typedef struct packed {
        logic                 gain_write;
        logic [GAIN_BITS-1:0] new_gain;
        logic                 duck_event;
        logic                 unduck_event;
        logic                 fast_tick;
    } result_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] loud_run;
        logic [COUNT_BITS-1:0] quiet_run;
    } runs_t;

endpackage

### design/sdf_cfg_regs.sv
module sdf_cfg_regs
    import sdf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_TRIGGER_LEVEL:    cfg_next.trigger_level    = cfg_data[GAIN_BITS-1:0];
                REG_DUCKED_GAIN:      cfg_next.ducked_gain      = cfg_data[GAIN_BITS-1:0];
                REG_FULL_GAIN:        cfg_next.full_gain        = cfg_data[GAIN_BITS-1:0];
                REG_RESTORE_GAIN:     cfg_next.restore_gain     = cfg_data[GAIN_BITS-1:0];
                REG_FADE_STEP:        cfg_next.fade_step        = cfg_data[GAIN_BITS-1:0];
                REG_TICKS_TO_DUCK:    cfg_next.ticks_to_duck    = cfg_data[COUNT_BITS-1:0];
                REG_TICKS_TO_RELEASE: cfg_next.ticks_to_release = cfg_data[COUNT_BITS-1:0];
                default:              cfg_next = cfg_reg;   // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level    <= TRIGGER_RST;
            cfg_reg.ducked_gain      <= DUCKED_RST;
            cfg_reg.full_gain        <= FULL_RST;
            cfg_reg.restore_gain     <= RESTORE_RST;
            cfg_reg.fade_step        <= STEP_RST;
            cfg_reg.ticks_to_duck    <= TO_DUCK_RST;
            cfg_reg.ticks_to_release <= TO_REL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/sdf_gain_calc.sv
module sdf_gain_calc
    import sdf_pkg::*;
(
    input  cfg_t    cfg,
    input  item_t   item,
    input  runs_t   runs,
    output runs_t   runs_upd,
    output result_t res
);

    logic [GAIN_BITS-1:0]  target;
    logic [GAIN_BITS-1:0]  diff;
    logic                  trans;
    logic                  loud;
    logic                  down;
    logic                  fade;
    logic [COUNT_BITS:0]   loud_inc;
    logic [COUNT_BITS:0]   quiet_inc;
    logic [COUNT_BITS-1:0] loud_sat;
    logic [COUNT_BITS-1:0] quiet_sat;
    runs_t                 runs_cnt;
    logic signed [GAIN_BITS+1:0] cur_s;
    logic signed [GAIN_BITS+1:0] step_s;
    logic signed [GAIN_BITS+1:0] ducked_s;
    logic signed [GAIN_BITS+1:0] full_s;
    logic signed [GAIN_BITS+1:0] moved;
    logic signed [GAIN_BITS+1:0] clamped;
    logic [GAIN_BITS-1:0]  faded_gain;

    always_comb
    begin
        if (item.bypass_on)
            target = cfg.restore_gain;
        else if (item.peak_level > cfg.trigger_level)
            target = cfg.ducked_gain;
        else
            target = cfg.full_gain;

        down  = item.present_gain > target;
        diff  = down ? (item.present_gain - target) : (target - item.present_gain);
        trans = diff > DIFF_TOL;
        loud  = target == cfg.ducked_gain;

        // saturating hold counts
        loud_inc  = {1'b0, runs.loud_run} + 1'b1;
        quiet_inc = {1'b0, runs.quiet_run} + 1'b1;
        loud_sat  = (loud_inc < {1'b0, cfg.ticks_to_duck}) ?
                    loud_inc[COUNT_BITS-1:0] : cfg.ticks_to_duck;
        quiet_sat = (quiet_inc < {1'b0, cfg.ticks_to_release}) ?
                    quiet_inc[COUNT_BITS-1:0] : cfg.ticks_to_release;
        runs_cnt.loud_run  = loud ? loud_sat : runs.loud_run;
        runs_cnt.quiet_run = loud ? runs.quiet_run : quiet_sat;
        fade = (runs_cnt.loud_run == cfg.ticks_to_duck) ||
               (runs_cnt.quiet_run == cfg.ticks_to_release);

        // one step, then raise to ducked, then lower to full
        cur_s    = $signed({2'b00, item.present_gain});
        step_s   = $signed({2'b00, cfg.fade_step});
        ducked_s = $signed({2'b00, cfg.ducked_gain});
        full_s   = $signed({2'b00, cfg.full_gain});
        moved    = down ? (cur_s - step_s) : (cur_s + step_s);
        clamped  = (moved < ducked_s) ? ducked_s : moved;
        clamped  = (clamped > full_s) ? full_s : clamped;
        faded_gain = clamped[GAIN_BITS-1:0];

        res      = '0;
        runs_upd = runs;
        if (item.channel_found)
        begin
            if (trans && !item.bypass_on)
            begin
                runs_upd = runs_cnt;
                if (fade)
                begin
                    res.gain_write         = 1'b1;
                    res.new_gain           = faded_gain;
                    res.fast_tick          = 1'b1;
                    res.duck_event         = down && (faded_gain == cfg.ducked_gain);
                    res.unduck_event       = !down && (item.present_gain == cfg.ducked_gain);
                    runs_upd.loud_run      = cfg.ticks_to_duck;
                    runs_upd.quiet_run     = cfg.ticks_to_release;
                end
            end
            else
            begin
                runs_upd = '0;
                if (trans)
                begin
                    res.gain_write   = 1'b1;
                    res.new_gain     = cfg.restore_gain;
                    res.unduck_event = item.present_gain == cfg.ducked_gain;
                end
            end
        end
    end

endmodule

### design/sidechain_ducking_fader.sv
// Channel | Handshake               | Payload
// --------+-------------------------+--------------------------------------------
// in      | in_valid / in_ready     | peak_level, present_gain, channel_found,
//         |                         | bypass_on
// out     | out_valid / out_ready   | gain_write, new_gain, duck_event,
//         |                         | unduck_event, fast_tick
// cfg     | cfg_we (write only)     | cfg_index, cfg_data
//
// One request per cycle sustained while the result is not stalled.
// The input register feeds the gain calculation, which loads the result register
// and the hold counters in the same cycle.
// Reset (rst_n, async, low) clears valids and hold counters; config regs take
// their defaults.
// A stalled result holds the pipeline; in_ready stays high while the input stage
// is empty or can hand its request on.
module sidechain_ducking_fader
    import sdf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [GAIN_BITS-1:0]     peak_level,
    input  logic [GAIN_BITS-1:0]     present_gain,
    input  logic                     channel_found,
    input  logic                     bypass_on,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     gain_write,
    output logic [GAIN_BITS-1:0]     new_gain,
    output logic                     duck_event,
    output logic                     unduck_event,
    output logic                     fast_tick
);

    cfg_t    cfg;

    // input stage
    item_t   item_reg;
    logic    in_valid_reg;

    // result stage
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;

    // hold counters
    runs_t   runs_reg;
    runs_t   runs_next;

    logic    out_load;   // result register free to take a request
    logic    advance;    // input stage hands its request on this cycle

    sdf_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdf_gain_calc u_gain_calc
    (
        .cfg      (cfg),
        .item     (item_reg),
        .runs     (runs_reg),
        .runs_upd (runs_next),
        .res      (result_next)
    );

    assign out_load = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_load;
    assign in_ready = !in_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            runs_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
            // counters move only when a request is actually processed
            if (advance)
                runs_reg <= runs_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.peak_level    <= peak_level;
            item_reg.present_gain  <= present_gain;
            item_reg.channel_found <= channel_found;
            item_reg.bypass_on     <= bypass_on;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign gain_write   = result_reg.gain_write;
    assign new_gain     = result_reg.new_gain;
    assign duck_event   = result_reg.duck_event;
    assign unduck_event = result_reg.unduck_event;
    assign fast_tick    = result_reg.fast_tick;

endmodule

### bench/testbench.sv
module testbench;
    import sdf_pkg::*;

    // Run limits, in clock cycles
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;  // long output stall, fills the pipe
    localparam int DRAIN_CYCLES = 6;    // settling margin after the last result

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;

    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [GAIN_BITS-1:0]     peak_level = '0;
    logic [GAIN_BITS-1:0]     present_gain = '0;
    logic                     channel_found = 1'b0;
    logic                     bypass_on = 1'b0;

    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     gain_write;
    logic [GAIN_BITS-1:0]     new_gain;
    logic                     duck_event;
    logic                     unduck_event;
    logic                     fast_tick;

    // Shadow of the register file and the two hold counters
    cfg_t                     regs;
    logic [COUNT_BITS-1:0]    loud_ticks;
    logic [COUNT_BITS-1:0]    quiet_ticks;

    // Expected fader decisions, oldest first
    result_t                  fader_outcomes[$];
    result_t                  last_outcome;

    int                       errors = 0;
    int                       cycles = 0;
    bit                       calm = 1'b0;     // no idling on either side
    bit                       hold_go = 1'b0;  // ask the output side for a long stall

    sidechain_ducking_fader dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .peak_level   (peak_level),
        .present_gain (present_gain),
        .channel_found(channel_found),
        .bypass_on    (bypass_on),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .gain_write   (gain_write),
        .new_gain     (new_gain),
        .duck_event   (duck_event),
        .unduck_event (unduck_event),
        .fast_tick    (fast_tick)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Saturating count towards a hold limit; a limit of zero pins it at zero
    function automatic logic [COUNT_BITS-1:0] run_bump(input logic [COUNT_BITS-1:0] run,
                                                       input logic [COUNT_BITS-1:0] lim);
        int n;
        n = int'(run) + 1;
        return (n < int'(lim)) ? COUNT_BITS'(n) : lim;
    endfunction

    // One tick of the fader; updates the shadow hold counters
    function automatic result_t fader_outcome(input item_t rq);
        result_t              r;
        logic [GAIN_BITS-1:0] target;
        logic [GAIN_BITS-1:0] distance;
        logic                 needs_move;
        logic                 going_down;
        int                   moved;
        r = '0;
        // missing channel: nothing out, counters untouched
        if (rq.channel_found)
        begin
            target = (rq.peak_level > regs.trigger_level) ? regs.ducked_gain
                                                          : regs.full_gain;
            if (rq.bypass_on)
                target = regs.restore_gain;
            distance = (rq.present_gain > target) ? rq.present_gain - target
                                                  : target - rq.present_gain;
            // tolerance of 0.001 of full scale, in exact integer form
            needs_move = (64'(distance) * 64'd1000) > (64'd1 << GAIN_BITS);

            if (needs_move && rq.bypass_on)
            begin
                r.gain_write   = 1'b1;
                r.new_gain     = regs.restore_gain;
                r.unduck_event = (rq.present_gain == regs.ducked_gain);
            end

            if (needs_move && !rq.bypass_on)
            begin
                // loud means the target value equals the ducked gain
                if (target == regs.ducked_gain)
                    loud_ticks = run_bump(loud_ticks, regs.ticks_to_duck);
                else
                    quiet_ticks = run_bump(quiet_ticks, regs.ticks_to_release);

                if (loud_ticks == regs.ticks_to_duck || quiet_ticks == regs.ticks_to_release)
                begin
                    going_down = rq.present_gain > target;
                    moved = going_down ? int'(rq.present_gain) - int'(regs.fade_step)
                                       : int'(rq.present_gain) + int'(regs.fade_step);
                    // raise to ducked first, then cap at full
                    if (moved < int'(regs.ducked_gain))
                        moved = int'(regs.ducked_gain);
                    if (moved > int'(regs.full_gain))
                        moved = int'(regs.full_gain);
                    r.gain_write   = 1'b1;
                    r.new_gain     = GAIN_BITS'(moved);
                    r.fast_tick    = 1'b1;
                    quiet_ticks    = regs.ticks_to_release;
                    loud_ticks     = regs.ticks_to_duck;
                    r.duck_event   = going_down && (r.new_gain == regs.ducked_gain);
                    r.unduck_event = !going_down && (rq.present_gain == regs.ducked_gain);
                end
            end
            else
            begin
                // bypassed or already on target
                loud_ticks  = '0;
                quiet_ticks = '0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Sampled just after the edge, so all values are those the DUT presented
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (fader_outcomes.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = fader_outcomes.pop_front();
                check_field("gain_write", int'(want.gain_write), int'(gain_write));
                check_field("new_gain", int'(want.new_gain), int'(new_gain));
                check_field("duck_event", int'(want.duck_event), int'(duck_event));
                check_field("unduck_event", int'(want.unduck_event), int'(unduck_event));
                check_field("fast_tick", int'(want.fast_tick), int'(fast_tick));
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, a quiet stretch, and one long hold-off
    // ------------------------------------------------------------------

    initial
    begin : output_side
        int hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // ------------------------------------------------------------------
    // Request side and register access (all called just after a rising edge)
    // ------------------------------------------------------------------

    function automatic item_t make_request(input logic [GAIN_BITS-1:0] peak,
                                           input logic [GAIN_BITS-1:0] present,
                                           input logic found, input logic bypass);
        item_t rq;
        rq.peak_level    = peak;
        rq.present_gain  = present;
        rq.channel_found = found;
        rq.bypass_on     = bypass;
        return rq;
    endfunction

    // Offer one request, hold it until accepted, then log its expected outcome.
    // in_valid stays high on return so back-to-back requests need no re-raise.
    task automatic send_tick(input item_t rq);
        while (!calm && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        peak_level    <= rq.peak_level;
        present_gain  <= rq.present_gain;
        channel_found <= rq.channel_found;
        bypass_on     <= rq.bypass_on;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_outcome = fader_outcome(rq);
        fader_outcomes.insert(fader_outcomes.size(), last_outcome);
    endtask

    // Stop offering, let every outstanding request come back, then settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (fader_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Block must be idle. Count registers get junk above their width.
    task automatic program_regs(input cfg_t c);
        write_reg(REG_TRIGGER_LEVEL, c.trigger_level);
        write_reg(REG_DUCKED_GAIN, c.ducked_gain);
        write_reg(REG_FULL_GAIN, c.full_gain);
        write_reg(REG_RESTORE_GAIN, c.restore_gain);
        write_reg(REG_FADE_STEP, c.fade_step);
        write_reg(REG_TICKS_TO_DUCK,
                  (CFG_DATA_BITS'($urandom) << COUNT_BITS) | CFG_DATA_BITS'(c.ticks_to_duck));
        write_reg(REG_TICKS_TO_RELEASE,
                  (CFG_DATA_BITS'($urandom) << COUNT_BITS)
                  | CFG_DATA_BITS'(c.ticks_to_release));
        cfg_we <= 1'b0;
        regs = c;
    endtask

    function automatic cfg_t random_settings();
        cfg_t                 c;
        logic [GAIN_BITS-1:0] t;
        c.ducked_gain = GAIN_BITS'($urandom_range(40000));
        c.full_gain   = GAIN_BITS'($urandom_range(65535, int'(c.ducked_gain)));
        // now and then an inverted range: every fade clamps to full
        if ($urandom_range(9) == 0)
        begin
            t             = c.ducked_gain;
            c.ducked_gain = c.full_gain;
            c.full_gain   = t;
        end
        c.trigger_level = GAIN_BITS'($urandom);
        case ($urandom_range(2))
            0:       c.restore_gain = GAIN_BITS'($urandom);
            1:       c.restore_gain = c.full_gain;
            default: c.restore_gain = c.ducked_gain;
        endcase
        c.fade_step = ($urandom_range(3) == 0) ? GAIN_BITS'($urandom)
                                               : GAIN_BITS'($urandom_range(8000, 500));
        c.ticks_to_duck = ($urandom_range(7) == 0) ? COUNT_BITS'($urandom)
                                                   : COUNT_BITS'($urandom_range(6));
        c.ticks_to_release = ($urandom_range(7) == 0) ? COUNT_BITS'($urandom)
                                                      : COUNT_BITS'($urandom_range(6));
        return c;
    endfunction

    // Closed-loop traffic: the channel gain follows every written gain, with
    // loud and quiet bursts so the hold counters reach their limits and fades
    // run to completion. A minority of requests are noise.
    task automatic run_programme(input int count);
        item_t                rq;
        int                   burst;
        int                   roll;
        bit                   loud;
        logic [GAIN_BITS-1:0] gain;
        gain = ($urandom_range(1) == 0) ? regs.full_gain : regs.ducked_gain;
        while (count > 0)
        begin
            burst = $urandom_range(40, 1);
            loud  = 1'($urandom_range(1));
            while (burst > 0 && count > 0)
            begin
                rq = make_request('0, gain, 1'b1, 1'b0);
                if (!loud)
                    rq.peak_level = GAIN_BITS'($urandom_range(int'(regs.trigger_level)));
                else if (regs.trigger_level == '1)
                    rq.peak_level = GAIN_BITS'($urandom);
                else
                    rq.peak_level = GAIN_BITS'($urandom_range(65535,
                                                              int'(regs.trigger_level) + 1));
                roll = $urandom_range(99);
                if (roll < 4)
                    rq = make_request(GAIN_BITS'($urandom), GAIN_BITS'($urandom), 1'b0,
                                      1'($urandom));
                else if (roll < 8)
                    rq.bypass_on = 1'b1;
                else if (roll < 12)
                    rq.present_gain = GAIN_BITS'($urandom);
                send_tick(rq);
                if (last_outcome.gain_write)
                    gain = last_outcome.new_gain;
                burst--;
                count--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: trigger 66, ducked 13107, full 65535, step 3277, holds 3/20
    task automatic test_directed_defaults();
        send_tick(make_request(16'hFFFF, 16'h0000, 1'b0, 1'b1));  // channel missing
        send_tick(make_request(16'h0000, 16'hFFFF, 1'b1, 1'b0));  // on target
        send_tick(make_request(16'd66, 16'd65470, 1'b1, 1'b0));   // peak at trigger, within tol
        send_tick(make_request(16'd66, 16'd65469, 1'b1, 1'b0));   // just outside tolerance
        // three loud ticks: fade down starts on the third
        repeat (3) send_tick(make_request(16'd67, 16'hFFFF, 1'b1, 1'b0));
        send_tick(make_request(16'hFFFF, 16'd16384, 1'b1, 1'b0)); // lands on ducked
        send_tick(make_request(16'hFFFF, 16'h0000, 1'b1, 1'b0));  // below ducked, clamped up
        send_tick(make_request(16'hFFFF, 16'd13107, 1'b1, 1'b1)); // bypass from ducked
        send_tick(make_request(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));  // bypass, already restored
        send_tick(make_request(16'h0000, 16'd65469, 1'b1, 1'b1)); // bypass, no unduck
        send_tick(make_request(16'h0000, 16'd13107, 1'b1, 1'b0)); // quiet after bypass
        send_tick(make_request(16'h0000, 16'h0000, 1'b0, 1'b0));  // missing keeps counters
        wait_drained();
    endtask

    // Zero hold limits, empty trigger range, inverted clamp range, zero step
    task automatic test_edge_settings();
        cfg_t c;
        c = '{trigger_level: '1, ducked_gain: '0, full_gain: '1, restore_gain: '0,
              fade_step: '1, ticks_to_duck: '0, ticks_to_release: '0};
        program_regs(c);
        send_tick(make_request(16'hFFFF, 16'h0000, 1'b1, 1'b0));  // unduck from zero
        send_tick(make_request(16'hFFFF, 16'h8000, 1'b1, 1'b0));  // overshoot capped
        send_tick(make_request(16'h1234, 16'h0000, 1'b1, 1'b1));  // bypass, on restore
        send_tick(make_request(16'h0000, 16'hFFFF, 1'b1, 1'b1));  // bypass writes zero
        wait_drained();

        c = '{trigger_level: '0, ducked_gain: '1, full_gain: '0, restore_gain: '1,
              fade_step: '0, ticks_to_duck: '0, ticks_to_release: '1};
        program_regs(c);
        send_tick(make_request(16'h0001, 16'h0000, 1'b1, 1'b0));  // loud, clamps to full
        send_tick(make_request(16'h0000, 16'hFFFF, 1'b1, 1'b0));  // quiet, loud count at limit
        send_tick(make_request(16'h0000, 16'h0000, 1'b1, 1'b0));  // on target
        wait_drained();
    endtask

    // Several register settings, the all-zero and all-one extremes first
    task automatic test_random_settings();
        cfg_t c;
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 0)
                c = '0;
            else if (phase == 1)
                c = '1;
            else
                c = random_settings();
            program_regs(c);
            run_programme((phase < 2) ? 60 : 200);
            wait_drained();
        end
    endtask

    // Output held off for a long stretch while requests keep coming
    task automatic test_stalled_output();
        program_regs(random_settings());
        hold_go = 1'b1;
        calm    = 1'b1;
        run_programme(150);
        calm    = 1'b0;
        wait_drained();
    endtask

    // Back-to-back traffic, no idling anywhere
    task automatic test_steady_stream();
        program_regs(random_settings());
        calm = 1'b1;
        run_programme(260);
        wait_drained();
        calm = 1'b0;
    endtask

    initial
    begin
        regs = '{trigger_level: TRIGGER_RST, ducked_gain: DUCKED_RST, full_gain: FULL_RST,
                 restore_gain: RESTORE_RST, fade_step: STEP_RST,
                 ticks_to_duck: TO_DUCK_RST, ticks_to_release: TO_REL_RST};
        loud_ticks  = '0;
        quiet_ticks = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_edge_settings();
        test_random_settings();
        test_stalled_output();
        test_steady_stream();

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### sim.f
design/sdf_pkg.sv
design/sdf_cfg_regs.sv
design/sdf_gain_calc.sv
design/sidechain_ducking_fader.sv
bench/testbench.sv
